@@ design/br1_pkg.sv @@
// shared types and constants for the byterun1 row decoder
// used by br1_adv and byterun1_row_decoder_unit; no dependencies
package br1_pkg;

  localparam int unsigned MAX_ROW_BYTES = 256;
  localparam int unsigned MAX_LINES     = 4096;

  localparam logic [7:0] CTRL_NOP = 8'h80;  // control byte -128

  // configuration register indexes
  localparam logic [1:0] REG_COMPRESSED = 2'd0;
  localparam logic [1:0] REG_ROW_BYTES  = 2'd1;
  localparam logic [1:0] REG_LINE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2
  } phase_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  // one step of the row position unit
  typedef struct packed {
    logic [1:0]  k;
    logic [8:0]  row_pos;
    logic [11:0] line_pos;
    logic        row_end;
    logic        image_end;
  } adv_t;

endpackage

@@ design/byterun1_row_decoder_unit.sv @@
// byterun1 (packbits) row decoder top level: control decode, sequencer
// and output register; depends on br1_pkg and br1_adv
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in       | input     | in_valid / in_stall  | in_byte
//  out      | output    | out_valid / out_stall| byte_first, byte_second,
//           |           |                      | byte_count, row_end, image_end,
//           |           |                      | overrun, last_of_input
//  cfg      | input     | cfg_we               | cfg_index, cfg_data
//
// a body byte is taken while the sequencer is idle; a byte that yields r
// results then holds the input until all are issued, one result per cycle
// through the row position unit while the output does not stall; a repeat
// run of n bytes yields results of up to two bytes each. control bytes and
// dropped literals yield nothing. a new byte is taken while the last result
// still waits in the output register. synchronous reset restores the
// register defaults and expects a control byte.
module byterun1_row_decoder_unit import br1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_first,
  output logic [7:0]  byte_second,
  output logic [1:0]  byte_count,
  output logic        row_end,
  output logic        image_end,
  output logic        overrun,
  output logic        last_of_input,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic        compressed;
  logic [8:0]  row_bytes;
  logic [12:0] line_count;

  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic [7:0]  run_left, run_left_next;
  logic        drop_rest, drop_rest_next;
  logic [8:0]  row_pos, row_pos_next;
  logic [11:0] line_pos, line_pos_next;
  logic [7:0]  rem, rem_next;
  logic        job_rep, job_rep_next;
  logic [7:0]  hold;

  logic        in_xfer;
  logic        out_free;
  logic        emit;
  logic        job_start;
  logic [7:0]  run_dec;
  logic [7:0]  rem_after;
  logic        res_last;
  logic        res_ov;
  adv_t        adv;

  br1_adv u_adv (
    .row_pos    (row_pos),
    .line_pos   (line_pos),
    .rem        (rem),
    .row_bytes  (row_bytes),
    .line_count (line_count),
    .adv        (adv)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == S_EMIT) && out_free;
  assign run_dec   = (run_left == 8'd0) ? 8'd0 : run_left - 8'd1;
  assign rem_after = rem - {6'd0, adv.k};
  assign res_last  = !job_rep || adv.row_end || (rem_after == 8'd0);
  // single results carry the literal count left, repeat results the run left
  assign res_ov    = adv.row_end &&
                     ((rem_after != 8'd0) || (!job_rep && run_left != 8'd0));

  // byte decode on input transfer, counter updates on each result
  always_comb begin
    phase_next     = phase;
    run_left_next  = run_left;
    drop_rest_next = drop_rest;
    row_pos_next   = row_pos;
    line_pos_next  = line_pos;
    rem_next       = rem;
    job_rep_next   = job_rep;
    job_start      = 1'b0;
    if (in_xfer) begin
      if (!compressed) begin
        phase_next     = PH_CTRL;
        run_left_next  = 8'd0;
        drop_rest_next = 1'b0;
        job_start      = 1'b1;
        job_rep_next   = 1'b0;
        rem_next       = 8'd1;
      end else begin
        case (phase)
          PH_LIT: begin
            run_left_next = run_dec;
            if (drop_rest) begin
              if (run_dec == 8'd0) begin
                phase_next     = PH_CTRL;
                drop_rest_next = 1'b0;
              end
            end else begin
              job_start    = 1'b1;
              job_rep_next = 1'b0;
              rem_next     = 8'd1;
            end
          end
          PH_REP: begin
            phase_next    = PH_CTRL;
            run_left_next = 8'd0;
            rem_next      = run_left;
            job_rep_next  = 1'b1;
            job_start     = (run_left != 8'd0);
          end
          default: begin
            if (!in_byte[7]) begin
              phase_next     = PH_LIT;
              run_left_next  = {1'b0, in_byte[6:0]} + 8'd1;
              drop_rest_next = 1'b0;
            end else if (in_byte != CTRL_NOP) begin
              phase_next    = PH_REP;
              run_left_next = 8'(9'd257 - {1'b0, in_byte});
            end else begin
              phase_next = PH_CTRL;
            end
          end
        endcase
      end
    end else if (emit) begin
      row_pos_next  = adv.row_pos;
      line_pos_next = adv.line_pos;
      rem_next      = rem_after;
      if (!job_rep) begin
        if (run_left == 8'd0) begin
          phase_next = PH_CTRL;
        end else if (adv.row_end) begin
          drop_rest_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (job_start) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit && res_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_CTRL;
      run_left  <= 8'd0;
      drop_rest <= 1'b0;
      row_pos   <= 9'd0;
      line_pos  <= 12'd0;
      rem       <= 8'd0;
      job_rep   <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      run_left  <= run_left_next;
      drop_rest <= drop_rest_next;
      row_pos   <= row_pos_next;
      line_pos  <= line_pos_next;
      rem       <= rem_next;
      job_rep   <= job_rep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed <= 1'b1;
      row_bytes  <= 9'd40;
      line_count <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMPRESSED: compressed <= cfg_data[0];
        REG_ROW_BYTES:  row_bytes  <= cfg_data[8:0];
        REG_LINE_COUNT: line_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_first    <= hold;
      byte_second   <= (adv.k == 2'd2) ? hold : 8'd0;
      byte_count    <= adv.k;
      row_end       <= adv.row_end;
      image_end     <= adv.image_end;
      overrun       <= res_ov;
      last_of_input <= res_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count == 2'd1 || byte_count == 2'd2))
    else $error("result with byte count outside one or two");

  a_overrun_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (overrun || image_end) |-> row_end)
    else $error("overrun or image end without row end");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 2'd1 |-> byte_second == 8'd0)
    else $error("second byte not cleared on a one-byte result");

  a_row_end_resets_pos: assert property (@(posedge clk) disable iff (rst)
    emit && adv.row_end |=> row_pos == 9'd0)
    else $error("row position not cleared after row end");

endmodule

@@ design/br1_adv.sv @@
// row position unit: clamps the row and line registers, picks how many
// bytes the next result holds and advances the row and line counters
// depends on br1_pkg
module br1_adv import br1_pkg::*; (
  input  logic [8:0]  row_pos,
  input  logic [11:0] line_pos,
  input  logic [7:0]  rem,
  input  logic [8:0]  row_bytes,
  input  logic [12:0] line_count,
  output adv_t        adv
);

  logic [8:0]  len;
  logic [12:0] lines;
  logic [8:0]  room;
  logic [1:0]  k;
  logic [8:0]  sum;
  logic [12:0] line_inc;

  always_comb begin
    if (row_bytes == 9'd0) begin
      len = 9'd1;
    end else if (row_bytes > 9'(MAX_ROW_BYTES)) begin
      len = 9'(MAX_ROW_BYTES);
    end else begin
      len = row_bytes;
    end

    if (line_count == 13'd0) begin
      lines = 13'd1;
    end else if (line_count > 13'(MAX_LINES)) begin
      lines = 13'(MAX_LINES);
    end else begin
      lines = line_count;
    end

    // a row already past its end after a register change gets one byte
    room = (row_pos < len) ? (len - row_pos) : 9'd1;

    k = (rem >= 8'd2) ? 2'd2 : rem[1:0];
    if (room == 9'd1 && k == 2'd2) begin
      k = 2'd1;
    end

    sum      = row_pos + {7'd0, k};
    line_inc = {1'b0, line_pos} + 13'd1;

    adv.k         = k;
    adv.row_end   = (sum >= len) || (sum == 9'd0);
    adv.row_pos   = adv.row_end ? 9'd0 : sum;
    adv.image_end = 1'b0;
    adv.line_pos  = line_pos;
    if (adv.row_end) begin
      if (line_inc >= lines) begin
        adv.line_pos  = 12'd0;
        adv.image_end = 1'b1;
      end else begin
        adv.line_pos = line_inc[11:0];
      end
    end
  end

endmodule
